// ----- rtl/wbf_pkg.sv -----
`timescale 1ns / 1ps

package wbf_pkg;

    // Word-break property classes, densely numbered; end of text is internal only.
    typedef logic [4:0] class_t;

    localparam class_t WB_OTHER        = 5'd0;
    localparam class_t WB_CR           = 5'd1;
    localparam class_t WB_LF           = 5'd2;
    localparam class_t WB_NEWLINE      = 5'd3;
    localparam class_t WB_EXTEND       = 5'd4;
    localparam class_t WB_JOINER       = 5'd5;
    localparam class_t WB_REGIONAL     = 5'd6;
    localparam class_t WB_FORMAT       = 5'd7;
    localparam class_t WB_KATAKANA     = 5'd8;
    localparam class_t WB_HEBREW       = 5'd9;
    localparam class_t WB_ALETTER      = 5'd10;
    localparam class_t WB_SQUOTE       = 5'd11;
    localparam class_t WB_DQUOTE       = 5'd12;
    localparam class_t WB_MIDNUM       = 5'd13;
    localparam class_t WB_MIDLETTER    = 5'd14;
    localparam class_t WB_MIDNUMLET    = 5'd15;
    localparam class_t WB_NUMERIC      = 5'd16;
    localparam class_t WB_EXTNUMLET    = 5'd17;
    localparam class_t WB_SPACE        = 5'd18;
    localparam class_t WB_PICTO        = 5'd19;
    localparam class_t WB_PICTO_LETTER = 5'd20;
    localparam class_t WB_END_TEXT     = 5'd21;

    localparam int CLASS_W         = 5;
    localparam int BYTES_W         = 3;
    localparam int S_DATA_W        = 8;
    localparam int SEG_LEN_W       = 16;
    localparam int M_USER_W        = 2;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int RESULT_SLOTS    = 3;

    // Result slots of one bundle, in emission order.
    typedef logic [1:0] slot_t;
    localparam slot_t SLOT_HELD  = 2'd0;
    localparam slot_t SLOT_BREAK = 2'd1;
    localparam slot_t SLOT_END   = 2'd2;

    typedef enum logic [1:0] {
        RAW_KEEP,
        RAW_BREAK,
        RAW_CONTEXT
    } raw_t;

    // All results caused by one input item.
    typedef struct packed {
        logic [RESULT_SLOTS-1:0]                mask;
        logic [RESULT_SLOTS-1:0]                sat;
        logic [RESULT_SLOTS-1:0][SEG_LEN_W-1:0] len;
    } bundle_t;

    function automatic logic is_ignorable(class_t c);
        return (c == WB_EXTEND) || (c == WB_FORMAT) || (c == WB_JOINER);
    endfunction

    function automatic logic is_letter_like(class_t c);
        return (c == WB_ALETTER) || (c == WB_PICTO_LETTER) || (c == WB_HEBREW);
    endfunction

    function automatic logic is_mid_quote(class_t c);
        return (c == WB_MIDNUMLET) || (c == WB_SQUOTE);
    endfunction

    function automatic logic is_newline(class_t c);
        return (c == WB_CR) || (c == WB_LF) || (c == WB_NEWLINE);
    endfunction

    // Rules on the raw neighbor pair, before ignorables are skipped.
    function automatic raw_t raw_rule(class_t p, class_t n);
        if (p == WB_CR && n == WB_LF) return RAW_KEEP;
        if (is_newline(p) || is_newline(n)) return RAW_BREAK;
        if (p == WB_JOINER && (n == WB_PICTO || n == WB_PICTO_LETTER)) return RAW_KEEP;
        if (p == WB_SPACE && n == WB_SPACE) return RAW_KEEP;
        if (is_ignorable(n)) return RAW_KEEP;
        return RAW_CONTEXT;
    endfunction

    // Context rules over two classes on either side; 1 = break.
    function automatic logic context_break(class_t p0, class_t p1, class_t n0,
                                           class_t n1, logic par);
        logic keep;
        keep = (is_letter_like(p0) && is_letter_like(n0))
            || (is_letter_like(p0) && (n0 == WB_MIDLETTER || is_mid_quote(n0))
                && is_letter_like(n1))
            || (is_letter_like(p1) && (p0 == WB_MIDLETTER || is_mid_quote(p0))
                && is_letter_like(n0))
            || (p0 == WB_HEBREW && n0 == WB_SQUOTE)
            || (p0 == WB_HEBREW && n0 == WB_DQUOTE && n1 == WB_HEBREW)
            || (p1 == WB_HEBREW && p0 == WB_DQUOTE && n0 == WB_HEBREW)
            || (p0 == WB_NUMERIC && n0 == WB_NUMERIC)
            || (is_letter_like(p0) && n0 == WB_NUMERIC)
            || (p0 == WB_NUMERIC && is_letter_like(n0))
            || (p1 == WB_NUMERIC && (p0 == WB_MIDNUM || is_mid_quote(p0))
                && n0 == WB_NUMERIC)
            || (p0 == WB_NUMERIC && (n0 == WB_MIDNUM || is_mid_quote(n0))
                && n1 == WB_NUMERIC)
            || (p0 == WB_KATAKANA && n0 == WB_KATAKANA)
            || ((is_letter_like(p0) || p0 == WB_NUMERIC || p0 == WB_KATAKANA
                 || p0 == WB_EXTNUMLET) && n0 == WB_EXTNUMLET)
            || (p0 == WB_EXTNUMLET && (is_letter_like(n0) || n0 == WB_NUMERIC
                 || n0 == WB_KATAKANA))
            || (n0 == WB_REGIONAL && par);
        return !keep;
    endfunction

endpackage

// ----- rtl/wbf_front.sv -----
`timescale 1ns / 1ps

module wbf_front #(
    parameter int LENGTH_BITS = wbf_pkg::LENGTH_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  wbf_pkg::class_t             word_class,
    input  logic [wbf_pkg::BYTES_W-1:0] code_point_bytes,
    input  logic                        end_of_text,
    input  logic                        queue_full,
    output logic                        push,
    output wbf_pkg::bundle_t            bundle
);

    localparam int CW = (LENGTH_BITS > 16) ? 16 : LENGTH_BITS;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] CAP = '1;

    logic            accept;
    wbf_pkg::class_t cls, n1;
    logic            ign, resolve, hold, brk_held, main_step;
    logic            brk_main, wait_la, keep_main;
    wbf_pkg::raw_t   raw;
    wbf_pkg::class_t ctx0_a, ctx1_a, base0, base1;
    logic            par_a, basep, fold_en, fresh;
    logic            brk_eot, brk_le, brk_hl, brk_nu;

    logic [CW-1:0]   bytes_cw;
    logic [SW-1:0]   sum_seg_aft, sum_seg_b, sum_aft_b, sum_all, sum_b;
    logic [CW-1:0]   seg1, seg1b;
    logic            over1, ov1b;

    logic            started_reg, started_next;
    logic            pend_reg, pend_next;
    wbf_pkg::class_t prior_reg, prior_next;
    wbf_pkg::class_t ctx0_reg, ctx0_next, ctx1_reg, ctx1_next;
    wbf_pkg::class_t look_reg, look_next;
    logic            parity_reg, parity_next;
    logic [CW-1:0]   seg_reg, seg_next, aft_reg, aft_next;
    logic            seg_over_reg, seg_over_next, aft_over_reg, aft_over_next;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign bytes_cw = CW'(code_point_bytes);

    // Four adders side by side so no add waits on another.
    assign sum_seg_aft = SW'(seg_reg) + SW'(aft_reg);
    assign sum_seg_b   = SW'(seg_reg) + SW'(code_point_bytes);
    assign sum_aft_b   = SW'(aft_reg) + SW'(code_point_bytes);
    assign sum_all     = SW'(seg_reg) + SW'(aft_reg) + SW'(code_point_bytes);

    always_comb begin
        cls = (word_class > wbf_pkg::WB_PICTO_LETTER) ? wbf_pkg::WB_OTHER : word_class;
        ign = wbf_pkg::is_ignorable(cls);

        // Settle a held boundary once its second lookahead class shows up.
        resolve  = started_reg && pend_reg && (!ign || end_of_text);
        hold     = started_reg && pend_reg && !resolve;
        n1       = ign ? wbf_pkg::WB_END_TEXT : cls;
        brk_held = wbf_pkg::context_break(ctx0_reg, ctx1_reg, look_reg, n1, parity_reg);

        if (resolve) begin
            ctx0_a = look_reg;
            ctx1_a = brk_held ? wbf_pkg::WB_END_TEXT : ctx0_reg;
            par_a  = brk_held ? (look_reg == wbf_pkg::WB_REGIONAL)
                              : (!parity_reg && look_reg == wbf_pkg::WB_REGIONAL);
        end else begin
            ctx0_a = ctx0_reg;
            ctx1_a = ctx1_reg;
            par_a  = parity_reg;
        end

        raw     = wbf_pkg::raw_rule(prior_reg, cls);
        brk_eot = wbf_pkg::context_break(ctx0_a, ctx1_a, cls, wbf_pkg::WB_END_TEXT, par_a);
        brk_le  = wbf_pkg::context_break(ctx0_a, ctx1_a, cls, wbf_pkg::WB_ALETTER, par_a);
        brk_hl  = wbf_pkg::context_break(ctx0_a, ctx1_a, cls, wbf_pkg::WB_HEBREW, par_a);
        brk_nu  = wbf_pkg::context_break(ctx0_a, ctx1_a, cls, wbf_pkg::WB_NUMERIC, par_a);

        // A boundary that still depends on the next class waits instead of breaking.
        main_step = started_reg && !hold;
        wait_la   = main_step && raw == wbf_pkg::RAW_CONTEXT && !end_of_text
                    && (brk_le != brk_eot || brk_hl != brk_eot || brk_nu != brk_eot);
        brk_main  = main_step && !wait_la && (raw == wbf_pkg::RAW_BREAK
                    || (raw == wbf_pkg::RAW_CONTEXT && brk_eot));
        keep_main = main_step && !brk_main && !wait_la;

        // Segment length after the held boundary is settled.
        if (resolve && brk_held) begin
            seg1  = aft_reg;
            over1 = aft_over_reg;
            sum_b = sum_aft_b;
        end else if (resolve) begin
            seg1  = (|sum_seg_aft[SW-1:CW]) ? CAP : sum_seg_aft[CW-1:0];
            over1 = seg_over_reg || aft_over_reg || (|sum_seg_aft[SW-1:CW]);
            sum_b = sum_all;
        end else begin
            seg1  = seg_reg;
            over1 = seg_over_reg;
            sum_b = sum_seg_b;
        end
        seg1b = (|sum_b[SW-1:CW]) ? CAP : sum_b[CW-1:0];
        ov1b  = over1 || (|sum_b[SW-1:CW]);

        // Fold this class into the context, starting afresh after a break.
        fold_en = !started_reg || brk_main || keep_main;
        fresh   = !started_reg || brk_main;
        base0   = fresh ? wbf_pkg::WB_END_TEXT : ctx0_a;
        base1   = fresh ? wbf_pkg::WB_END_TEXT : ctx1_a;
        basep   = fresh ? 1'b0 : par_a;
        if (fold_en && !ign) begin
            ctx0_next   = cls;
            ctx1_next   = base0;
            parity_next = !basep && cls == wbf_pkg::WB_REGIONAL;
        end else if (fold_en) begin
            ctx0_next   = base0;
            ctx1_next   = base1;
            parity_next = basep;
        end else begin
            ctx0_next   = ctx0_a;
            ctx1_next   = ctx1_a;
            parity_next = par_a;
        end

        prior_next    = cls;
        look_next     = wait_la ? cls : look_reg;
        aft_next      = aft_reg;
        aft_over_next = aft_over_reg;
        if (!started_reg || brk_main) begin
            seg_next      = bytes_cw;
            seg_over_next = 1'b0;
        end else if (hold) begin
            seg_next      = seg_reg;
            seg_over_next = seg_over_reg;
            aft_next      = (|sum_aft_b[SW-1:CW]) ? CAP : sum_aft_b[CW-1:0];
            aft_over_next = aft_over_reg || (|sum_aft_b[SW-1:CW]);
        end else if (wait_la) begin
            seg_next      = seg1;
            seg_over_next = over1;
            aft_next      = bytes_cw;
            aft_over_next = 1'b0;
        end else begin
            seg_next      = seg1b;
            seg_over_next = ov1b;
        end

        started_next = !end_of_text;
        pend_next    = !end_of_text && (hold || wait_la);

        bundle = '0;
        bundle.mask[wbf_pkg::SLOT_HELD]  = resolve && brk_held;
        bundle.len[wbf_pkg::SLOT_HELD]   = wbf_pkg::SEG_LEN_W'(seg_reg);
        bundle.sat[wbf_pkg::SLOT_HELD]   = seg_over_reg;
        bundle.mask[wbf_pkg::SLOT_BREAK] = brk_main;
        bundle.len[wbf_pkg::SLOT_BREAK]  = wbf_pkg::SEG_LEN_W'(seg1);
        bundle.sat[wbf_pkg::SLOT_BREAK]  = over1;
        bundle.mask[wbf_pkg::SLOT_END]   = end_of_text;
        bundle.len[wbf_pkg::SLOT_END]    = wbf_pkg::SEG_LEN_W'(seg_next);
        bundle.sat[wbf_pkg::SLOT_END]    = seg_over_next;
    end

    assign push = accept && (|bundle.mask);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (accept) begin
            started_reg <= started_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prior_reg    <= prior_next;
            ctx0_reg     <= ctx0_next;
            ctx1_reg     <= ctx1_next;
            look_reg     <= look_next;
            parity_reg   <= parity_next;
            seg_reg      <= seg_next;
            seg_over_reg <= seg_over_next;
            aft_reg      <= aft_next;
            aft_over_reg <= aft_over_next;
        end
    end

    a_pend_in_string: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> started_reg)
        else $error("held boundary outside a string");

    a_eot_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && end_of_text |-> push && bundle.mask[wbf_pkg::SLOT_END])
        else $error("end of text without final segment");

endmodule

// ----- rtl/wbf_queue.sv -----
`timescale 1ns / 1ps

module wbf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_i,
    input  wbf_pkg::bundle_t push_data,
    output logic             full_o,
    input  logic             pop_i,
    output wbf_pkg::bundle_t pop_data,
    output logic             empty_o
);

    localparam int DEPTH = wbf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wbf_pkg::bundle_t   store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full_o   = (count_reg == CNT_W'(DEPTH));
    assign empty_o  = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb begin
        case ({push_i, pop_i})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop_i)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) store_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("push into full queue");

endmodule

// ----- rtl/wbf_back.sv -----
`timescale 1ns / 1ps

module wbf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wbf_pkg::bundle_t              q_data,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wbf_pkg::SEG_LEN_W-1:0] segment_length,
    output logic                          length_saturated,
    output logic                          string_done,
    output logic                          last_of_run
);

    wbf_pkg::bundle_t                  cur_reg;
    logic [wbf_pkg::RESULT_SLOTS-1:0]  mask_reg, pick, mask_left;
    wbf_pkg::slot_t                    slot;
    logic                              hs, need_load;

    // Present the lowest pending slot; the bundle retires with its last slot.
    always_comb begin
        if (mask_reg[wbf_pkg::SLOT_HELD]) begin
            slot = wbf_pkg::SLOT_HELD;
        end else if (mask_reg[wbf_pkg::SLOT_BREAK]) begin
            slot = wbf_pkg::SLOT_BREAK;
        end else begin
            slot = wbf_pkg::SLOT_END;
        end
        pick       = '0;
        pick[slot] = 1'b1;
        mask_left  = mask_reg & ~pick;
    end

    assign out_valid        = |mask_reg;
    assign hs               = out_valid && out_ready;
    assign need_load        = !out_valid || (hs && mask_left == '0);
    assign q_pop            = need_load && !q_empty;
    assign segment_length   = cur_reg.len[slot];
    assign length_saturated = cur_reg.sat[slot];
    assign string_done      = pick[wbf_pkg::SLOT_END];
    assign last_of_run      = (mask_left == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (need_load) begin
            mask_reg <= q_empty ? '0 : q_data.mask;
        end else if (hs) begin
            mask_reg <= mask_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_data;
    end

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && string_done |-> last_of_run)
        else $error("final segment not last of its run");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        hs && !last_of_run |=> out_valid)
        else $error("result run cut short");

endmodule

// ----- rtl/unicode_word_boundary_finder.sv -----
// Path: results go through the result queue, then the output register behind m_tvalid;
// a boundary held for lookahead is offered after the item that settles it.
// Throughput: one item per cycle while the queue has room; k results of one item leave
// as k output transfers; a four-entry result queue absorbs bursts before s_tready drops.
// Reset: aresetn is synchronous, active low, clears string state, queue and output.
`timescale 1ns / 1ps

module unicode_word_boundary_finder #(
    parameter int LENGTH_BITS = wbf_pkg::LENGTH_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input code points
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wbf_pkg::S_DATA_W-1:0]   s_tdata,   // [4:0] word_class, [7:5] code_point_bytes
    input  logic                           s_tlast,   // end_of_text
    // word segments
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wbf_pkg::SEG_LEN_W-1:0]  m_tdata,   // [15:0] segment_length
    output logic [wbf_pkg::M_USER_W-1:0]   m_tuser,   // [0] length_saturated, [1] string_done
    output logic                           m_tlast    // last_of_run
);

    wbf_pkg::bundle_t push_data, pop_data;
    logic             push, pop, q_full, q_empty;
    logic             seg_sat, str_done;

    // Front: take one item per cycle while the queue has room, apply the boundary
    // rules, and collect every result the item causes into one bundle.
    wbf_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .word_class       (s_tdata[wbf_pkg::CLASS_W-1:0]),
        .code_point_bytes (s_tdata[wbf_pkg::CLASS_W +: wbf_pkg::BYTES_W]),
        .end_of_text      (s_tlast),
        .queue_full       (q_full),
        .push             (push),
        .bundle           (push_data)
    );

    // Hold bundles so the rule logic keeps going while the sink stalls.
    wbf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (push),
        .push_data (push_data),
        .full_o    (q_full),
        .pop_i     (pop),
        .pop_data  (pop_data),
        .empty_o   (q_empty)
    );

    // Back: drain each bundle in order, one segment per cycle while m_tready is high.
    wbf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_data           (pop_data),
        .q_empty          (q_empty),
        .q_pop            (pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .segment_length   (m_tdata),
        .length_saturated (seg_sat),
        .string_done      (str_done),
        .last_of_run      (m_tlast)
    );

    assign m_tuser = {str_done, seg_sat};

endmodule

// ----- tb/sv/wbf_tb_pkg.sv -----
`timescale 1ns / 1ps

package wbf_tb_pkg;

    import wbf_pkg::*;

    typedef struct packed {
        logic [SEG_LEN_W-1:0] len;
        logic                 sat;
        logic                 done;
        logic                 last;
    } segment_t;

    class segment_scoreboard;

        // Mirror of the finder's string state.
        class_t       prev_raw;
        class_t       ctx0;
        class_t       ctx1;
        class_t       held_class;
        bit           ri_odd;
        bit           holding;
        bit           started;
        int unsigned  seg_len;
        bit           seg_sat;
        int unsigned  held_len;
        bit           held_sat;
        int unsigned  len_cap;

        segment_t     segments_due[$];

        int unsigned  errors;
        int unsigned  checked;
        int unsigned  strings;
        int unsigned  settled;
        int unsigned  saturated;

        function new(int len_bits);
            len_cap = (1 << ((len_bits > 16) ? 16 : len_bits)) - 1;
            errors = 0;
            checked = 0;
            strings = 0;
            settled = 0;
            saturated = 0;
            clear_string();
        endfunction

        function void clear_string();
            prev_raw = WB_END_TEXT;
            ctx0 = WB_END_TEXT;
            ctx1 = WB_END_TEXT;
            held_class = WB_END_TEXT;
            ri_odd = 1'b0;
            holding = 1'b0;
            started = 1'b0;
            seg_len = 0;
            seg_sat = 1'b0;
            held_len = 0;
            held_sat = 1'b0;
        endfunction

        function bit skip_class(class_t c);
            return c inside {WB_EXTEND, WB_FORMAT, WB_JOINER};
        endfunction

        function bit letterish(class_t c);
            return c inside {WB_ALETTER, WB_PICTO_LETTER, WB_HEBREW};
        endfunction

        function bit mid_quote(class_t c);
            return c inside {WB_MIDNUMLET, WB_SQUOTE};
        endfunction

        function bit line_break(class_t c);
            return c inside {WB_CR, WB_LF, WB_NEWLINE};
        endfunction

        function raw_t pair_rule(class_t p, class_t n);
            if (p == WB_CR && n == WB_LF) return RAW_KEEP;
            if (line_break(p) || line_break(n)) return RAW_BREAK;
            if (p == WB_JOINER && n inside {WB_PICTO, WB_PICTO_LETTER}) return RAW_KEEP;
            if (p == WB_SPACE && n == WB_SPACE) return RAW_KEEP;
            if (skip_class(n)) return RAW_KEEP;
            return RAW_CONTEXT;
        endfunction

        // 1 when the context splits the text between p0 and n0.
        function bit splits(class_t p0, class_t p1, class_t n0, class_t n1, bit par);
            bit mid_l0;
            bit mid_lp;
            mid_l0 = (n0 == WB_MIDLETTER) || mid_quote(n0);
            mid_lp = (p0 == WB_MIDLETTER) || mid_quote(p0);
            if (letterish(p0) && letterish(n0)) return 1'b0;
            if (letterish(p0) && mid_l0 && letterish(n1)) return 1'b0;
            if (letterish(p1) && mid_lp && letterish(n0)) return 1'b0;
            if (p0 == WB_HEBREW && n0 == WB_SQUOTE) return 1'b0;
            if (p0 == WB_HEBREW && n0 == WB_DQUOTE && n1 == WB_HEBREW) return 1'b0;
            if (p1 == WB_HEBREW && p0 == WB_DQUOTE && n0 == WB_HEBREW) return 1'b0;
            if (p0 == WB_NUMERIC && (n0 == WB_NUMERIC || letterish(n0))) return 1'b0;
            if (letterish(p0) && n0 == WB_NUMERIC) return 1'b0;
            if (p1 == WB_NUMERIC && (p0 == WB_MIDNUM || mid_quote(p0))
                && n0 == WB_NUMERIC) return 1'b0;
            if (p0 == WB_NUMERIC && (n0 == WB_MIDNUM || mid_quote(n0))
                && n1 == WB_NUMERIC) return 1'b0;
            if (p0 == WB_KATAKANA && n0 == WB_KATAKANA) return 1'b0;
            if ((letterish(p0) || p0 inside {WB_NUMERIC, WB_KATAKANA, WB_EXTNUMLET})
                && n0 == WB_EXTNUMLET) return 1'b0;
            if (p0 == WB_EXTNUMLET
                && (letterish(n0) || n0 inside {WB_NUMERIC, WB_KATAKANA})) return 1'b0;
            if (n0 == WB_REGIONAL && par) return 1'b0;
            return 1'b1;
        endfunction

        function int unsigned capped(int unsigned acc, int unsigned add, inout bit over);
            int unsigned sum;
            sum = acc + add;
            if (sum > len_cap) begin
                sum = len_cap;
                over = 1'b1;
            end
            return sum;
        endfunction

        function void shift_context(class_t c, bit fresh);
            if (fresh) begin
                ctx0 = WB_END_TEXT;
                ctx1 = WB_END_TEXT;
                ri_odd = 1'b0;
            end
            if (!skip_class(c)) begin
                ri_odd = !ri_odd && (c == WB_REGIONAL);
                ctx1 = ctx0;
                ctx0 = c;
            end
        endfunction

        function void close_segment(bit done);
            segment_t s;
            s.len = seg_len[SEG_LEN_W-1:0];
            s.sat = seg_sat;
            s.done = done;
            s.last = 1'b0;
            segments_due.push_back(s);
        endfunction

        // Work out the segments one accepted code point completes.
        function void note_input(class_t cls, logic [BYTES_W-1:0] nbytes, logic eot);
            class_t      c;
            class_t      ahead;
            class_t      next_real;
            raw_t        rule;
            bit          brk;
            bit          must_wait;
            int unsigned base;
            base = segments_due.size();
            c = (cls > WB_PICTO_LETTER) ? WB_OTHER : cls;
            if (!started) begin
                started = 1'b1;
                prev_raw = c;
                shift_context(c, 1'b1);
                seg_sat = 1'b0;
                seg_len = capped(0, nbytes, seg_sat);
            end else begin
                // settle a held boundary once its second class shows up
                if (holding && (!skip_class(c) || eot)) begin
                    next_real = skip_class(c) ? WB_END_TEXT : c;
                    ahead = held_class;
                    brk = splits(ctx0, ctx1, ahead, next_real, ri_odd);
                    if (brk) begin
                        close_segment(1'b0);
                        seg_len = held_len;
                        seg_sat = held_sat;
                    end else begin
                        seg_sat = seg_sat | held_sat;
                        seg_len = capped(seg_len, held_len, seg_sat);
                    end
                    shift_context(ahead, brk);
                    holding = 1'b0;
                    held_len = 0;
                    held_sat = 1'b0;
                    settled++;
                end
                if (holding) begin
                    held_len = capped(held_len, nbytes, held_sat);
                end else begin
                    rule = pair_rule(prev_raw, c);
                    brk = (rule == RAW_BREAK);
                    must_wait = 1'b0;
                    if (rule == RAW_CONTEXT) begin
                        brk = splits(ctx0, ctx1, c, WB_END_TEXT, ri_odd);
                        if (!eot &&
                            (splits(ctx0, ctx1, c, WB_ALETTER, ri_odd) != brk ||
                             splits(ctx0, ctx1, c, WB_HEBREW, ri_odd) != brk ||
                             splits(ctx0, ctx1, c, WB_NUMERIC, ri_odd) != brk))
                            must_wait = 1'b1;
                    end
                    if (must_wait) begin
                        holding = 1'b1;
                        held_class = c;
                        held_sat = 1'b0;
                        held_len = capped(0, nbytes, held_sat);
                    end else if (brk) begin
                        close_segment(1'b0);
                        seg_sat = 1'b0;
                        seg_len = capped(0, nbytes, seg_sat);
                        shift_context(c, 1'b1);
                    end else begin
                        seg_len = capped(seg_len, nbytes, seg_sat);
                        shift_context(c, 1'b0);
                    end
                end
                prev_raw = c;
            end
            if (eot) begin
                close_segment(1'b1);
                clear_string();
                strings++;
            end
            if (segments_due.size() > base) segments_due[$].last = 1'b1;
        endfunction

        function void check_result(logic [SEG_LEN_W-1:0] len, logic sat, logic done,
                                   logic last);
            segment_t want;
            if (segments_due.size() == 0) begin
                $error("segment of length %0d arrived with none outstanding", len);
                errors++;
                return;
            end
            want = segments_due.pop_front();
            checked++;
            if (sat) saturated++;
            if (len !== want.len) begin
                $error("segment_length: expected %0d, got %0d", want.len, len);
                errors++;
            end
            if (sat !== want.sat) begin
                $error("length_saturated: expected %0b, got %0b", want.sat, sat);
                errors++;
            end
            if (done !== want.done) begin
                $error("string_done: expected %0b, got %0b", want.done, done);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function void final_check();
            if (segments_due.size() != 0) begin
                $error("%0d segments never arrived", segments_due.size());
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_unicode_word_boundary_finder.sv -----
`timescale 1ns / 1ps

module tb_unicode_word_boundary_finder;

    import wbf_pkg::*;
    import wbf_tb_pkg::*;

    localparam int LEN_BITS     = LENGTH_BITS_DEF;
    // Cycles without any handshake before the run is declared hung; well above the
    // longest receiver hold-off plus the random gaps.
    localparam int HANG_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    // Letters in the full-rate stretch with no idling on either side.
    localparam int FAST_RUN     = 24;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;    // [4:0] word_class, [7:5] code_point_bytes
    logic                  s_tlast  = 1'b0;  // end_of_text
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SEG_LEN_W-1:0]  m_tdata;          // [15:0] segment_length
    logic [M_USER_W-1:0]   m_tuser;          // [0] length_saturated, [1] string_done
    logic                  m_tlast;          // last_of_run

    segment_scoreboard     sb = new(LEN_BITS);

    bit                    no_gaps       = 1'b0;  // suppress random idling on both sides
    int unsigned           hold_request  = 0;     // receiver hold-off asked by stimulus
    int unsigned           hold_left     = 0;
    int unsigned           items_sent    = 0;
    int unsigned           quiet_cycles  = 0;

    unicode_word_boundary_finder #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: check each accepted segment, then pick m_tready for the next cycle.
    // Values are read right after the edge, before any nonblocking update lands.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            // pick up a hold-off request and count it down here
            if (hold_left == 0 && hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= no_gaps || ($urandom_range(99) >= 35);
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d segments outstanding",
                     HANG_LIMIT, sb.segments_due.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one code point, idle at random first, hold it until accepted.
    // s_tvalid stays high into the next call so back-to-back items need no toggle.
    task automatic send_item(class_t cls, logic [BYTES_W-1:0] nbytes, logic eot);
        while (!no_gaps && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {nbytes, cls};
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(cls, nbytes, eot);
        items_sent++;
    endtask

    // Drop the input valid and hold until every segment owed has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.segments_due.size() != 0) @(posedge aclk);
    endtask

    // Weighted class pick: half word-forming classes, so the letter, number
    // and quote rules see real sequences; a share of out-of-range codes.
    function automatic class_t pick_class();
        int unsigned sel;
        class_t      word_set [11];
        class_t      skip_set [3];
        class_t      gap_set  [4];
        word_set = '{WB_ALETTER, WB_HEBREW, WB_PICTO_LETTER, WB_NUMERIC, WB_MIDLETTER,
                     WB_MIDNUM, WB_MIDNUMLET, WB_SQUOTE, WB_DQUOTE, WB_EXTNUMLET,
                     WB_KATAKANA};
        skip_set = '{WB_EXTEND, WB_FORMAT, WB_JOINER};
        gap_set  = '{WB_CR, WB_LF, WB_NEWLINE, WB_SPACE};
        sel = $urandom_range(99);
        if (sel < 50) return word_set[$urandom_range(10)];
        if (sel < 64) return skip_set[$urandom_range(2)];
        if (sel < 74) return WB_REGIONAL;
        if (sel < 84) return gap_set[$urandom_range(3)];
        if (sel < 93) return ($urandom_range(1) != 0) ? WB_PICTO : WB_OTHER;
        return class_t'($urandom_range(31));
    endfunction

    // One string of random length, closed by end_of_text; noise strings use any code.
    task automatic send_string(bit noise);
        int unsigned         cp_count;
        int unsigned         k;
        class_t              cls;
        logic [BYTES_W-1:0]  nbytes;
        cp_count = $urandom_range(14, 1);
        for (k = 0; k < cp_count; k++) begin
            cls = noise ? class_t'($urandom_range(31)) : pick_class();
            if ($urandom_range(9) == 0)
                nbytes = BYTES_W'($urandom_range(7));
            else
                nbytes = BYTES_W'($urandom_range(4, 1));
            send_item(cls, nbytes, k == cp_count - 1);
        end
    endtask

    task automatic random_strings(int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target)
            send_string($urandom_range(99) < 12);
    endtask

    initial begin
        int unsigned k;
        int unsigned directed_items;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every class but MidNumLet, byte counts 0 to 7, out-of-range codes,
        // lookahead kept and broken, a held boundary settled by end of text.
        send_item(WB_ALETTER,      3'd1, 1'b0);
        send_item(WB_MIDLETTER,    3'd1, 1'b0);   // held for its lookahead
        send_item(WB_ALETTER,      3'd2, 1'b0);   // lookahead keeps the word
        send_item(WB_MIDLETTER,    3'd1, 1'b0);
        send_item(WB_EXTEND,       3'd3, 1'b0);   // skipped while held
        send_item(WB_OTHER,        3'd4, 1'b0);   // lookahead breaks
        send_item(WB_HEBREW,       3'd1, 1'b0);
        send_item(WB_DQUOTE,       3'd1, 1'b0);
        send_item(WB_HEBREW,       3'd2, 1'b0);
        send_item(WB_SQUOTE,       3'd1, 1'b1);
        send_item(WB_NUMERIC,      3'd3, 1'b0);
        send_item(WB_MIDNUM,       3'd1, 1'b0);   // held
        send_item(WB_FORMAT,       3'd5, 1'b1);   // end of text settles it
        send_item(WB_REGIONAL,     3'd4, 1'b0);
        send_item(WB_REGIONAL,     3'd4, 1'b0);
        send_item(WB_REGIONAL,     3'd4, 1'b0);
        send_item(WB_KATAKANA,     3'd3, 1'b0);
        send_item(WB_KATAKANA,     3'd3, 1'b0);
        send_item(WB_EXTNUMLET,    3'd1, 1'b0);
        send_item(WB_CR,           3'd1, 1'b0);
        send_item(WB_LF,           3'd1, 1'b0);
        send_item(WB_NEWLINE,      3'd2, 1'b0);
        send_item(WB_SPACE,        3'd1, 1'b0);
        send_item(WB_SPACE,        3'd6, 1'b0);
        send_item(WB_JOINER,       3'd3, 1'b0);
        send_item(WB_PICTO,        3'd4, 1'b0);
        send_item(WB_PICTO_LETTER, 3'd4, 1'b0);
        send_item(WB_END_TEXT,     3'd0, 1'b0);   // unknown code, taken as Other
        send_item(class_t'(31),    3'd7, 1'b1);   // all ones in both fields
        directed_items = items_sent;
        wait_drained();

        // Hold the receiver off while items keep coming, so the result queue
        // fills and the input stalls.
        hold_request = HOLD_CYCLES;
        random_strings(120);
        // Pause the sender until every owed segment has come out.
        wait_drained();

        // Full rate with no idling on either side: a letter run, then a held
        // boundary trailed by a run of ignorables.
        no_gaps = 1'b1;
        for (k = 0; k < FAST_RUN; k++)
            send_item(WB_ALETTER, 3'd7, 1'b0);
        send_item(WB_OTHER, 3'd1, 1'b1);
        send_item(WB_ALETTER, 3'd1, 1'b0);
        send_item(WB_MIDLETTER, 3'd1, 1'b0);
        for (k = 0; k < FAST_RUN / 2; k++)
            send_item(WB_EXTEND, 3'd7, 1'b0);
        send_item(WB_OTHER, 3'd2, 1'b0);
        send_item(WB_OTHER, 3'd2, 1'b1);
        no_gaps = 1'b0;

        random_strings(230);

        wait_drained();
        repeat (16) @(posedge aclk);
        sb.final_check();

        $display("%0d code points (%0d directed) in %0d strings, %0d segments checked",
                 items_sent, directed_items, sb.strings, sb.checked);
        $display("%0d held boundaries settled, %0d saturated segments, one %0d-cycle hold-off",
                 sb.settled, sb.saturated, HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/wbf_pkg.sv
rtl/wbf_front.sv
rtl/wbf_queue.sv
rtl/wbf_back.sv
rtl/unicode_word_boundary_finder.sv
tb/sv/wbf_tb_pkg.sv
tb/sv/tb_unicode_word_boundary_finder.sv
